// ===== sv/bpc_pkg.sv =====
// Package for the barometric pressure compensation block.
// Holds field widths, shift amounts, thresholds and shared types; depends on nothing.

package bpc_pkg;

    localparam int COEF_W    = 16;
    localparam int RAW_W     = 24;
    localparam int DT_W      = RAW_W + 1;
    localparam int PRD_W     = COEF_W + DT_W;
    localparam int TS_SH     = 23;
    localparam int OFF_SH    = 6;
    localparam int SENS_SH   = 7;
    localparam int T2_SH     = 31;
    localparam int A_W       = PRD_W - TS_SH;
    localparam int B_W       = A_W + 1;
    localparam int TEMP_W    = 19;
    localparam int T2_W      = 18;
    localparam int SQ_W      = 35;
    localparam int OFF_W     = 40;
    localparam int SENS_W    = 40;
    localparam int SLO_W     = 20;
    localparam int SHI_W     = SENS_W - SLO_W;
    localparam int PPLO_W    = RAW_W + SLO_W;
    localparam int PPHI_W    = RAW_W + 1 + SHI_W;
    localparam int PROD_W    = 64;
    localparam int PROD_SH   = 21;
    localparam int X_W       = PROD_W - PROD_SH + 1;
    localparam int P_SH      = 15;
    localparam int P_W       = X_W - P_SH;
    localparam int PRES_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int T_REF     = 2000;
    localparam int A_VCOLD   = 3500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_BASE   = 3'd0,
        REG_OFF_BASE    = 3'd1,
        REG_SENS_TEMPCO = 3'd2,
        REG_OFF_TEMPCO  = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] sens_base;
        logic [COEF_W-1:0] off_base;
        logic [COEF_W-1:0] sens_tempco;
        logic [COEF_W-1:0] off_tempco;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } t_coef;

    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic [TEMP_W-1:0] temp;
        logic [OFF_W-1:0]  off;
        logic [SENS_W-1:0] sens;
        logic [T2_W-1:0]   t2;
        logic [SQ_W-1:0]   asq;
        logic [SQ_W-1:0]   bsq;
        logic              low;
        logic              vlow;
    } t_mid;

endpackage

// ===== sv/bpc_coef_regs.sv =====
// Calibration coefficient register file for the pressure compensation block.
// Depends on bpc_pkg for the register indices and the coefficient struct.

module bpc_coef_regs import bpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_coef                o_coef
);

    t_coef r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_SENS_BASE:   r_coef.sens_base   <= i_cfg_data;
                REG_OFF_BASE:    r_coef.off_base    <= i_cfg_data;
                REG_SENS_TEMPCO: r_coef.sens_tempco <= i_cfg_data;
                REG_OFF_TEMPCO:  r_coef.off_tempco  <= i_cfg_data;
                REG_REF_TEMP:    r_coef.ref_temp    <= i_cfg_data;
                REG_TEMP_SLOPE:  r_coef.temp_slope  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== sv/bpc_front.sv =====
// Front half of the compensation pipeline: dT, first-order terms and the squares.
// Four register stages; depends on bpc_pkg for widths and the t_mid struct.

module bpc_front import bpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RAW_W-1:0] i_d1,
    input  logic [RAW_W-1:0] i_d2,
    input  t_coef            i_coef,
    output logic             o_vld,
    output t_mid             o_mid
);

    logic r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld;

    logic [RAW_W-1:0]        r_f1_d1;
    logic signed [DT_W-1:0]  r_f1_dt;

    logic [RAW_W-1:0]        r_f2_d1;
    logic [PRD_W-1:0]        r_f2_pt;
    logic [PRD_W-1:0]        r_f2_po;
    logic [PRD_W-1:0]        r_f2_ps;
    logic [T2_W-1:0]         r_f2_t2;

    logic [RAW_W-1:0]        r_f3_d1;
    logic signed [A_W-1:0]   r_f3_a;
    logic signed [B_W-1:0]   r_f3_b;
    logic [TEMP_W-1:0]       r_f3_temp;
    logic [OFF_W-1:0]        r_f3_off;
    logic [SENS_W-1:0]       r_f3_sens;
    logic [T2_W-1:0]         r_f3_t2;
    logic                    r_f3_low;
    logic                    r_f3_vlow;

    t_mid                    r_f4_mid;

    logic signed [DT_W-1:0]   n_dt;
    logic signed [PRD_W:0]    n_pt;
    logic signed [PRD_W:0]    n_po;
    logic signed [PRD_W:0]    n_ps;
    logic signed [2*DT_W-1:0] n_dsq;
    logic signed [A_W-1:0]    n_a;
    logic signed [2*A_W-1:0]  n_asq;
    logic signed [2*B_W-1:0]  n_bsq;

    assign n_dt  = $signed({1'b0, i_d2}) - $signed({1'b0, i_coef.ref_temp, 8'd0});
    assign n_pt  = $signed({1'b0, i_coef.temp_slope}) * r_f1_dt;
    assign n_po  = $signed({1'b0, i_coef.off_tempco}) * r_f1_dt;
    assign n_ps  = $signed({1'b0, i_coef.sens_tempco}) * r_f1_dt;
    assign n_dsq = r_f1_dt * r_f1_dt;
    assign n_a   = $signed(r_f2_pt[PRD_W-1:TS_SH]);
    assign n_asq = r_f3_a * r_f3_a;
    assign n_bsq = r_f3_b * r_f3_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
        end else if (i_en) begin
            r_f1_vld <= i_vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_d1   <= i_d1;
            r_f1_dt   <= n_dt;

            r_f2_d1   <= r_f1_d1;
            r_f2_pt   <= n_pt[PRD_W-1:0];
            r_f2_po   <= n_po[PRD_W-1:0];
            r_f2_ps   <= n_ps[PRD_W-1:0];
            r_f2_t2   <= n_dsq[T2_SH+T2_W-1:T2_SH];

            r_f3_d1   <= r_f2_d1;
            r_f3_a    <= n_a;
            r_f3_b    <= $signed({n_a[A_W-1], n_a}) + B_W'(A_VCOLD);
            r_f3_temp <= $signed({n_a[A_W-1], n_a}) + TEMP_W'(T_REF);
            r_f3_off  <= {{(OFF_W-COEF_W-17){1'b0}}, i_coef.off_base, 17'd0}
                       + {{(OFF_W-PRD_W+OFF_SH){r_f2_po[PRD_W-1]}},
                          r_f2_po[PRD_W-1:OFF_SH]};
            r_f3_sens <= {{(SENS_W-COEF_W-16){1'b0}}, i_coef.sens_base, 16'd0}
                       + {{(SENS_W-PRD_W+SENS_SH){r_f2_ps[PRD_W-1]}},
                          r_f2_ps[PRD_W-1:SENS_SH]};
            r_f3_t2   <= r_f2_t2;
            r_f3_low  <= n_a[A_W-1];
            r_f3_vlow <= (n_a < -A_VCOLD);

            r_f4_mid.d1   <= r_f3_d1;
            r_f4_mid.temp <= r_f3_temp;
            r_f4_mid.off  <= r_f3_off;
            r_f4_mid.sens <= r_f3_sens;
            r_f4_mid.t2   <= r_f3_t2;
            r_f4_mid.asq  <= n_asq[SQ_W-1:0];
            r_f4_mid.bsq  <= n_bsq[SQ_W-1:0];
            r_f4_mid.low  <= r_f3_low;
            r_f4_mid.vlow <= r_f3_vlow;
        end
    end

    assign o_vld = r_f4_vld;
    assign o_mid = r_f4_mid;

    a_vlow_implies_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f3_vld && r_f3_vlow |-> r_f3_low)
        else $error("extra cold correction flagged above the cold threshold");

endmodule

// ===== sv/bpc_back.sv =====
// Back half of the compensation pipeline: second-order corrections and the pressure product.
// Four register stages ending in the output registers; depends on bpc_pkg.

module bpc_back import bpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_mid              i_mid,
    output logic              o_vld,
    output logic [TEMP_W-1:0] o_temp,
    output logic [PRES_W-1:0] o_pres
);

    logic r_b1_vld, r_b2_vld, r_b3_vld, r_b4_vld;

    logic [RAW_W-1:0]  r_b1_d1;
    logic [TEMP_W-1:0] r_b1_temp;
    logic [OFF_W-1:0]  r_b1_off;
    logic [SENS_W-1:0] r_b1_sens;

    logic [TEMP_W-1:0] r_b2_temp;
    logic [OFF_W-1:0]  r_b2_off;
    logic [PPLO_W-1:0] r_b2_pplo;
    logic [PPHI_W-1:0] r_b2_pphi;

    logic [TEMP_W-1:0] r_b3_temp;
    logic [OFF_W-1:0]  r_b3_off;
    logic [PROD_W-1:0] r_b3_prod;

    logic [TEMP_W-1:0] r_b4_temp;
    logic [PRES_W-1:0] r_b4_pres;

    logic [SQ_W+5:0]            n_asq61;
    logic [SQ_W+3:0]            n_bsq15;
    logic [OFF_W-1:0]           n_off2;
    logic [SENS_W-1:0]          n_sens2;
    logic [TEMP_W:0]            n_temp;
    logic [PPLO_W-1:0]          n_pplo;
    logic signed [PPHI_W-1:0]   n_pphi;
    logic [X_W-1:0]             n_x;

    assign n_asq61 = {i_mid.asq, 6'd0} - {4'd0, i_mid.asq, 2'd0} + {6'd0, i_mid.asq};
    assign n_bsq15 = {i_mid.bsq, 4'd0} - {4'd0, i_mid.bsq};

    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        if (i_mid.low) begin
            n_off2  = {{(OFF_W-SQ_W-2){1'b0}}, n_asq61[SQ_W+5:4]};
            n_sens2 = {{(SENS_W-SQ_W-1){1'b0}}, i_mid.asq, 1'b0};
            if (i_mid.vlow) begin
                n_off2  = n_off2 + {{(OFF_W-SQ_W-4){1'b0}}, n_bsq15};
                n_sens2 = n_sens2 + {{(SENS_W-SQ_W-3){1'b0}}, i_mid.bsq, 3'd0};
            end
        end
    end

    assign n_temp = {i_mid.temp[TEMP_W-1], i_mid.temp}
                  - {{(TEMP_W+1-T2_W){1'b0}}, (i_mid.low ? i_mid.t2 : {T2_W{1'b0}})};

    assign n_pplo = r_b1_d1 * r_b1_sens[SLO_W-1:0];
    assign n_pphi = $signed({1'b0, r_b1_d1}) * $signed(r_b1_sens[SENS_W-1:SLO_W]);

    assign n_x = {r_b3_prod[PROD_W-1], r_b3_prod[PROD_W-1:PROD_SH]}
               - {{(X_W-OFF_W){r_b3_off[OFF_W-1]}}, r_b3_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
        end else if (i_en) begin
            r_b1_vld <= i_vld;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
            r_b4_vld <= r_b3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_d1   <= i_mid.d1;
            r_b1_temp <= n_temp[TEMP_W-1:0];
            r_b1_off  <= i_mid.off - n_off2;
            r_b1_sens <= i_mid.sens - n_sens2;

            r_b2_temp <= r_b1_temp;
            r_b2_off  <= r_b1_off;
            r_b2_pplo <= n_pplo;
            r_b2_pphi <= n_pphi;

            r_b3_temp <= r_b2_temp;
            r_b3_off  <= r_b2_off;
            r_b3_prod <= {r_b2_pphi[PROD_W-SLO_W-1:0], {SLO_W{1'b0}}}
                       + {{(PROD_W-PPLO_W){1'b0}}, r_b2_pplo};

            // The pressure cannot leave a 29-bit signed range, so widening is all
            // the saturation needs.
            r_b4_temp <= r_b3_temp;
            r_b4_pres <= {{(PRES_W-P_W){n_x[X_W-1]}}, n_x[X_W-1:P_SH]};
        end
    end

    assign o_vld  = r_b4_vld;
    assign o_temp = r_b4_temp;
    assign o_pres = r_b4_pres;

endmodule

// ===== sv/barometric_pressure_compensation_top.sv =====
// Top level of the barometric pressure compensation block.
// Instantiates bpc_coef_regs, bpc_front and bpc_back; depends on bpc_pkg.
//
// The input channel (i_valid, o_ready) carries one pair of raw conversions,
// pressure and temperature. The output channel (o_valid, i_ready) returns the
// compensated temperature in hundredths of a degree and the pressure in pascals.
// Six 16-bit calibration coefficients are written through i_cfg_we, i_cfg_idx
// and i_cfg_data while the block is idle; writes to unused indices are dropped.
// Every transfer in yields exactly one transfer out, in order.
// The result of an input transfer passes through the eight register stages of the
// multiplier chain and is then offered on the output.
// Throughput is one item per cycle while the receiver keeps i_ready high.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_ready falls in the same cycle, so nothing is lost or repeated.
// Reset clears the coefficients to zero and empties the pipeline.

module barometric_pressure_compensation_top import bpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [RAW_W-1:0]     i_raw_pressure,
    input  logic [RAW_W-1:0]     i_raw_temperature,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [TEMP_W-1:0]    o_temperature_centi,
    output logic [PRES_W-1:0]    o_pressure_pa,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_coef w_coef;
    t_mid  w_mid;
    logic  w_mid_vld;
    logic  w_out_vld;
    logic  w_en;

    assign w_en    = !w_out_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = w_out_vld;

    bpc_coef_regs u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    bpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_d1    (i_raw_pressure),
        .i_d2    (i_raw_temperature),
        .i_coef  (w_coef),
        .o_vld   (w_mid_vld),
        .o_mid   (w_mid)
    );

    bpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mid_vld),
        .i_mid   (w_mid),
        .o_vld   (w_out_vld),
        .o_temp  (o_temperature_centi),
        .o_pres  (o_pressure_pa)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while a result is stalled");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused with no result waiting");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

endmodule

// ===== dv/tb_barometric_pressure_compensation_top.sv =====
// Self-checking testbench for barometric_pressure_compensation_top.
// Drives raw conversion pairs through several coefficient settings and checks each result
// against a behavioural model of the compensation; depends on bpc_pkg and the block.
`timescale 1ns / 1ps

module tb_barometric_pressure_compensation_top;
    import bpc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_NS     = 1;
    localparam int COLD_EDGE     = -1500;
    localparam int DRAIN_CYCLES  = 16;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam longint RAW_TOP   = (64'sd1 << RAW_W) - 1;
    localparam longint PRES_HI   = 64'sd2147483647;
    localparam longint PRES_LO   = -64'sd2147483648;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
    } t_raw_pair;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [PRES_W-1:0] pres;
    } t_comp_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [RAW_W-1:0]     i_raw_pressure = '0;
    logic [RAW_W-1:0]     i_raw_temperature = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [TEMP_W-1:0]    o_temperature_centi;
    logic [PRES_W-1:0]    o_pressure_pa;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;

    t_raw_pair    raw_pending[$];
    t_comp_result comp_expected[$];
    t_coef        coef_mirror = '0;
    logic         in_fire = 1'b0;
    int           error_count = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    int           stall_cycle = 0;
    t_stall_mode  stall_mode = STALL_NONE;
    logic [15:0]  stall_pattern = '1;

    barometric_pressure_compensation_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    function automatic t_comp_result compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2,
                                                t_coef c);
        longint dt, temp, off, sens, t2, off2, sens2, a, b, p;
        t_comp_result r;
        dt    = longint'(d2) - (longint'(c.ref_temp) <<< 8);
        temp  = T_REF + ((longint'(c.temp_slope) * dt) >>> TS_SH);
        off   = (longint'(c.off_base) <<< 17) + ((longint'(c.off_tempco) * dt) >>> OFF_SH);
        sens  = (longint'(c.sens_base) <<< 16) + ((longint'(c.sens_tempco) * dt) >>> SENS_SH);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < T_REF) begin
            a     = temp - T_REF;
            t2    = (dt * dt) >>> T2_SH;
            off2  = (61 * a * a) >>> 4;
            sens2 = 2 * a * a;
            if (temp < COLD_EDGE) begin
                b     = temp - COLD_EDGE;
                off2  = off2 + 15 * b * b;
                sens2 = sens2 + 8 * b * b;
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = (((longint'(d1) * sens) >>> PROD_SH) - off) >>> P_SH;
        if (p > PRES_HI) begin
            p = PRES_HI;
        end
        if (p < PRES_LO) begin
            p = PRES_LO;
        end
        r.temp = TEMP_W'(temp);
        r.pres = PRES_W'(p);
        return r;
    endfunction

    function automatic void queue_pair(longint d1, longint d2);
        raw_pending.push_back(t_raw_pair'{RAW_W'(d1), RAW_W'(d2)});
    endfunction

    // Extremes of both fields, the 20.00 C threshold and the -15.00 C threshold.
    function automatic void queue_corners(t_coef c);
        longint ref_raw, cold_dt, v;
        ref_raw = longint'(c.ref_temp) <<< 8;
        queue_pair(0, 0);
        queue_pair(RAW_MAX, RAW_MAX);
        queue_pair(0, RAW_MAX);
        queue_pair(RAW_MAX, 0);
        queue_pair(RAW_MAX, ref_raw);
        if (ref_raw > 0) begin
            queue_pair($urandom, ref_raw - 1);
        end
        if (c.temp_slope != 0) begin
            cold_dt = -((longint'(A_VCOLD) <<< TS_SH) / longint'(c.temp_slope));
            v = ref_raw + cold_dt;
            if (v >= 1) begin
                queue_pair($urandom, v);
                queue_pair(RAW_MAX, v - 1);
            end
        end
    endfunction

    function automatic void queue_random(t_coef c, int count);
        longint ref_raw, d1, d2;
        ref_raw = longint'(c.ref_temp) <<< 8;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: d2 = longint'($urandom) & RAW_TOP;
                1: d2 = ref_raw + $urandom_range(0, 8191) - 4096;
                2: d2 = $urandom_range(0, 1 << 20);
                default: d2 = ref_raw - $urandom_range(0, 1 << 22);
            endcase
            if (d2 < 0) begin
                d2 = 0;
            end
            if (d2 > RAW_TOP) begin
                d2 = RAW_TOP;
            end
            case ($urandom_range(0, 15))
                0: d1 = 0;
                1: d1 = RAW_TOP;
                default: d1 = longint'($urandom) & RAW_TOP;
            endcase
            queue_pair(d1, d2);
        end
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COEF_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
    endtask

    task automatic load_coefs(t_coef c);
        write_reg(REG_SENS_BASE, c.sens_base);
        write_reg(REG_OFF_BASE, c.off_base);
        write_reg(REG_SENS_TEMPCO, c.sens_tempco);
        write_reg(REG_OFF_TEMPCO, c.off_tempco);
        write_reg(REG_REF_TEMP, c.ref_temp);
        write_reg(REG_TEMP_SLOPE, c.temp_slope);
        write_reg(CFG_IDX_SPARE_LO, COEF_W'($urandom));
        write_reg(CFG_IDX_SPARE_HI, COEF_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // The state is looked at once the driver's updates of this edge have settled.
    task automatic wait_idle();
        while (raw_pending.size() != 0 || i_valid || comp_expected.size() != 0) begin
            @(negedge i_clk);
            #(SETTLE_NS);
        end
    endtask

    always #CLK_HALF i_clk = ~i_clk;

    always @(negedge i_clk) begin
        t_raw_pair pair;
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (raw_pending.size() != 0) begin
                pair = raw_pending.pop_front();
                i_raw_pressure    <= pair.d1;
                i_raw_temperature <= pair.d2;
                i_valid           <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        logic rdy;
        stall_cycle++;
        if (stall_cycle % 96 == 0) begin
            stall_mode    = t_stall_mode'($urandom_range(0, 3));
            stall_pattern = 16'($urandom);
        end
        case (stall_mode)
            STALL_NONE:    rdy = 1'b1;
            STALL_LIGHT:   rdy = ($urandom_range(0, 3) != 0);
            STALL_PATTERN: rdy = stall_pattern[stall_cycle % 16];
            default:       rdy = 1'($urandom_range(0, 1));
        endcase
        i_ready <= rdy;
    end

    always @(posedge i_clk) begin
        t_comp_result want;
        if (!i_rst_n) begin
            coef_mirror <= '0;
            in_fire     <= 1'b0;
        end else begin
            in_fire <= i_valid && o_ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SENS_BASE:   coef_mirror.sens_base   <= i_cfg_data;
                    REG_OFF_BASE:    coef_mirror.off_base    <= i_cfg_data;
                    REG_SENS_TEMPCO: coef_mirror.sens_tempco <= i_cfg_data;
                    REG_OFF_TEMPCO:  coef_mirror.off_tempco  <= i_cfg_data;
                    REG_REF_TEMP:    coef_mirror.ref_temp    <= i_cfg_data;
                    REG_TEMP_SLOPE:  coef_mirror.temp_slope  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                comp_expected.push_back(compensate(i_raw_pressure, i_raw_temperature,
                                                   coef_mirror));
            end
            if (o_valid && i_ready) begin
                if (comp_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0d / %0d",
                             $time, $signed(o_temperature_centi), $signed(o_pressure_pa));
                end else begin
                    want = comp_expected.pop_front();
                    if (o_temperature_centi !== want.temp) begin
                        error_count++;
                        $display("%0t: temperature_centi expected %0d, actual %0d",
                                 $time, $signed(want.temp), $signed(o_temperature_centi));
                    end
                    if (o_pressure_pa !== want.pres) begin
                        error_count++;
                        $display("%0t: pressure_pa expected %0d, actual %0d",
                                 $time, $signed(want.pres), $signed(o_pressure_pa));
                    end
                end
            end
        end
    end

    initial begin
        t_coef setting;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Coefficients as left by reset.
        setting = '0;
        queue_corners(setting);
        queue_random(setting, 40);

        wait_idle();
        setting.sens_base   = 16'd46372;
        setting.off_base    = 16'd43981;
        setting.sens_tempco = 16'd29059;
        setting.off_tempco  = 16'd27842;
        setting.ref_temp    = 16'd31553;
        setting.temp_slope  = 16'd28165;
        load_coefs(setting);
        queue_corners(setting);
        queue_random(setting, 200);

        wait_idle();
        setting = '1;
        load_coefs(setting);
        queue_corners(setting);
        queue_random(setting, 150);

        wait_idle();
        setting = '0;
        load_coefs(setting);
        queue_random(setting, 40);

        for (int k = 0; k < 4; k++) begin
            wait_idle();
            setting.sens_base   = pick_coef();
            setting.off_base    = pick_coef();
            setting.sens_tempco = pick_coef();
            setting.off_tempco  = pick_coef();
            setting.ref_temp    = pick_coef();
            setting.temp_slope  = pick_coef();
            load_coefs(setting);
            queue_random(setting, 150);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("barometric_pressure_compensation_top regression: pass");
        end else begin
            $display("barometric_pressure_compensation_top regression: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("barometric_pressure_compensation_top regression: fail");
        $finish;
    end

endmodule
